### design/bale_pkg.sv
`default_nettype none

package bale_pkg;

  // Default list capacity.
  localparam int unsigned CapacityDefault = 16;

  // Fixed field widths of the request and result ports.
  localparam int unsigned FuncW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FoundW  = 4;
  localparam int unsigned CountW  = 5;

  // Operation codes carried by a request.
  typedef enum logic [FuncW-1:0] {
    FN_INSERT   = 3'd0,
    FN_DELETE   = 3'd1,
    FN_LOCATE   = 3'd2,
    FN_RETRIEVE = 3'd3,
    FN_SORTED   = 3'd4
  } func_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_WRITE_NEW,
    S_RD_ISSUE,
    S_RD_DATA,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

### design/bounded_array_list_engine.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_stall_o   in_func_i, in_value_i, in_position_i
// result    out        out_valid_o / out_stall_i out_status_o, out_read_value_o,
//                                                out_found_index_o, out_entry_count_o
//
// One request at a time; entries sit in one RAM with registered read, one entry per cycle.
// Insert and sorted insert shift the entries above the position up and then write the new
// value; delete shifts them down; locate scans every entry; retrieve reads one entry.
// Failed checks (full, bad position, unused code) go straight to the final state.
// A stalled result holds the next request only in its final state until the output
// register frees up. Reset clears the count and control state; the RAM is not cleared.
module bounded_array_list_engine #(
  parameter int unsigned CAPACITY = bale_pkg::CapacityDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [bale_pkg::FuncW-1:0]   in_func_i,
  input  wire logic [bale_pkg::ValueW-1:0]  in_value_i,
  input  wire logic [bale_pkg::PosW-1:0]    in_position_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [bale_pkg::StatusW-1:0]      out_status_o,
  output logic [bale_pkg::ValueW-1:0]       out_read_value_o,
  output logic [bale_pkg::FoundW-1:0]       out_found_index_o,
  output logic [bale_pkg::CountW-1:0]       out_entry_count_o
);

  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned IW  = $clog2(CAPACITY);
  localparam int unsigned PW  = (CW > bale_pkg::PosW) ? CW : bale_pkg::PosW;
  localparam int unsigned FW  = (IW > bale_pkg::FoundW) ? IW : bale_pkg::FoundW;
  localparam int unsigned OCW = (CW > bale_pkg::CountW) ? CW : bale_pkg::CountW;

  bale_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              pend_q, pend_d;
  logic              hit_q, hit_d;
  logic [bale_pkg::FuncW-1:0]  func_q, func_d;
  logic [bale_pkg::ValueW-1:0] value_q, value_d;
  bale_pkg::status_e res_status_q, res_status_d;
  logic [bale_pkg::ValueW-1:0] res_read_q, res_read_d;
  logic [IW-1:0]     res_found_q, res_found_d;
  logic              out_valid_q, out_valid_d;
  bale_pkg::status_e out_status_q, out_status_d;
  logic [bale_pkg::ValueW-1:0] out_read_q, out_read_d;
  logic [bale_pkg::FoundW-1:0] out_found_q, out_found_d;
  logic [bale_pkg::CountW-1:0] out_count_q, out_count_d;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [bale_pkg::ValueW-1:0] ram_wdata, ram_rdata;

  logic [PW-1:0]     pos_ext, cnt_ext;
  logic [CW-1:0]     ptr_m1;
  logic [FW-1:0]     found_ext;
  logic [OCW-1:0]    count_ext;
  logic              is_full, ins_bad, acc_bad;
  logic              less, equal, sort_stop, out_free;

  // Entry storage.
  bale_ram #(
    .WIDTH(bale_pkg::ValueW),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Request checks and compares against the entry just read.
  always_comb begin
    pos_ext   = PW'(in_position_i);
    cnt_ext   = PW'(cnt_q);
    is_full   = (cnt_q == CW'(CAPACITY));
    ins_bad   = (pos_ext > cnt_ext);
    acc_bad   = (pos_ext >= cnt_ext);
    less      = ($signed(value_q) < $signed(ram_rdata));
    equal     = (value_q == ram_rdata);
    sort_stop = (func_q == bale_pkg::FN_SORTED) && pend_q && less;
    ptr_m1    = ptr_q - 1'b1;
    out_free  = !out_valid_q || !out_stall_i;
    found_ext = FW'(res_found_q);
    count_ext = OCW'(cnt_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bale_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (in_func_i)
            bale_pkg::FN_INSERT:   state_d = (is_full || ins_bad) ? bale_pkg::S_DONE
                                                                  : bale_pkg::S_SHIFT_UP;
            bale_pkg::FN_DELETE:   state_d = acc_bad ? bale_pkg::S_DONE : bale_pkg::S_SHIFT_DN;
            bale_pkg::FN_LOCATE:   state_d = bale_pkg::S_SCAN;
            bale_pkg::FN_RETRIEVE: state_d = acc_bad ? bale_pkg::S_DONE : bale_pkg::S_RD_ISSUE;
            bale_pkg::FN_SORTED:   state_d = is_full ? bale_pkg::S_DONE : bale_pkg::S_SCAN;
            default:               state_d = bale_pkg::S_DONE;
          endcase
        end
      end
      bale_pkg::S_SCAN: begin
        if (sort_stop) begin
          state_d = bale_pkg::S_SHIFT_UP;
        end else if (!pend_q && (ptr_q == cnt_q)) begin
          state_d = (func_q == bale_pkg::FN_SORTED) ? bale_pkg::S_SHIFT_UP : bale_pkg::S_DONE;
        end
      end
      bale_pkg::S_SHIFT_UP: begin
        if (!pend_q && (ptr_q == pos_q)) begin
          state_d = bale_pkg::S_WRITE_NEW;
        end
      end
      bale_pkg::S_SHIFT_DN: begin
        if (!pend_q && (ptr_q >= cnt_q)) begin
          state_d = bale_pkg::S_DONE;
        end
      end
      bale_pkg::S_WRITE_NEW: state_d = bale_pkg::S_DONE;
      bale_pkg::S_RD_ISSUE:  state_d = bale_pkg::S_RD_DATA;
      bale_pkg::S_RD_DATA:   state_d = bale_pkg::S_DONE;
      bale_pkg::S_DONE: begin
        if (out_free) begin
          state_d = bale_pkg::S_IDLE;
        end
      end
      default: state_d = bale_pkg::S_IDLE;
    endcase
  end

  // RAM accesses and datapath updates for each state.
  always_comb begin
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    hit_d        = hit_q;
    func_d       = func_q;
    value_d      = value_q;
    res_status_d = res_status_q;
    res_read_d   = res_read_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_read_d   = out_read_q;
    out_found_d  = out_found_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = '0;
    ram_raddr    = '0;
    ram_wdata    = ram_rdata;
    in_stall_o   = (state_q != bale_pkg::S_IDLE);

    case (state_q)
      bale_pkg::S_IDLE: begin
        if (in_valid_i) begin
          func_d       = in_func_i;
          value_d      = in_value_i;
          pos_d        = CW'(in_position_i);
          pend_d       = 1'b0;
          hit_d        = 1'b0;
          res_status_d = bale_pkg::ST_OK;
          res_read_d   = '0;
          res_found_d  = '0;
          case (in_func_i)
            bale_pkg::FN_INSERT: begin
              ptr_d = cnt_q;
              if (is_full) begin
                res_status_d = bale_pkg::ST_FULL;
              end else if (ins_bad) begin
                res_status_d = bale_pkg::ST_BADPOS;
              end
            end
            bale_pkg::FN_DELETE: begin
              ptr_d = CW'(in_position_i) + 1'b1;
              if (acc_bad) begin
                res_status_d = bale_pkg::ST_BADPOS;
              end
            end
            bale_pkg::FN_LOCATE: ptr_d = '0;
            bale_pkg::FN_RETRIEVE: begin
              if (acc_bad) begin
                res_status_d = bale_pkg::ST_BADPOS;
              end
            end
            bale_pkg::FN_SORTED: begin
              ptr_d = '0;
              if (is_full) begin
                res_status_d = bale_pkg::ST_FULL;
              end
            end
            default: ;
          endcase
        end
      end

      // Stream entries from the bottom: record the last match, or stop at the
      // first entry greater than the value for a sorted insert.
      bale_pkg::S_SCAN: begin
        if (pend_q && (func_q == bale_pkg::FN_LOCATE) && equal) begin
          hit_d       = 1'b1;
          res_found_d = idx_q;
        end
        if (sort_stop) begin
          pos_d  = CW'(idx_q);
          ptr_d  = cnt_q;
          pend_d = 1'b0;
        end else if (ptr_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[IW-1:0];
          idx_d     = ptr_q[IW-1:0];
          ptr_d     = ptr_q + 1'b1;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (func_q == bale_pkg::FN_SORTED) begin
              pos_d = cnt_q;
              ptr_d = cnt_q;
            end else if (!hit_q) begin
              res_status_d = bale_pkg::ST_NOTFOUND;
            end
          end
        end
      end

      // Move entries up one place, top first, reading one below each write.
      bale_pkg::S_SHIFT_UP: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(idx_q + 1'b1);
        end
        if (ptr_q > pos_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_m1[IW-1:0];
          idx_d     = ptr_m1[IW-1:0];
          ptr_d     = ptr_m1;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end

      // Put the new value in the opened slot.
      bale_pkg::S_WRITE_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[IW-1:0];
        ram_wdata = value_q;
        cnt_d     = cnt_q + 1'b1;
      end

      // Move entries down one place, bottom first.
      bale_pkg::S_SHIFT_DN: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(idx_q - 1'b1);
        end
        if (ptr_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[IW-1:0];
          idx_d     = ptr_q[IW-1:0];
          ptr_d     = ptr_q + 1'b1;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end

      bale_pkg::S_RD_ISSUE: begin
        ram_re    = 1'b1;
        ram_raddr = pos_q[IW-1:0];
      end

      bale_pkg::S_RD_DATA: res_read_d = ram_rdata;

      // Hand the result to the output register once it is free.
      bale_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_read_d   = res_read_q;
          out_found_d  = found_ext[bale_pkg::FoundW-1:0];
          out_count_d  = count_ext[bale_pkg::CountW-1:0];
        end
      end

      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bale_pkg::S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    hit_q        <= hit_d;
    func_q       <= func_d;
    value_q      <= value_d;
    res_status_q <= res_status_d;
    res_read_q   <= res_read_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_read_q   <= out_read_d;
    out_found_q  <= out_found_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_read_value_o  = out_read_q;
  assign out_found_index_o = out_found_q;
  assign out_entry_count_o = out_count_q;

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // The count moves by at most one per request.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> (cnt_q == CW'($past(cnt_q) + 1'b1)) ||
                        (cnt_q == CW'($past(cnt_q) - 1'b1)))
    else $error("entry count jumped");

  // A shift never reads and writes the same entry in one cycle.
  a_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write collide");

  // A full status is only given for a full list.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == bale_pkg::S_DONE) && (res_status_q == bale_pkg::ST_FULL))
      |-> (cnt_q == CW'(CAPACITY)))
    else $error("full status on a list with room");

  // A result appears only out of the final state.
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == bale_pkg::S_DONE))
    else $error("result raised outside the final state");

endmodule

`default_nettype wire

### design/bale_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module bale_ram #(
  parameter int unsigned WIDTH = bale_pkg::ValueW,
  parameter int unsigned DEPTH = bale_pkg::CapacityDefault,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
